/* rtl/spectral_peak_picker_defines.svh */
// assertion macros shared by the peak picker checkers
`ifndef SPECTRAL_PEAK_PICKER_DEFINES_SVH
`define SPECTRAL_PEAK_PICKER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SPP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SPP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/spp_pkg.sv */
// shared types and constants of the spectral peak picker
`default_nettype none

package spp_pkg;

    localparam int MAX_PEAKS = 8;
    localparam int MAX_BINS  = 4096;
    localparam int BIN_W     = $clog2(MAX_BINS);
    localparam int HELD_W    = $clog2(MAX_PEAKS + 1);
    localparam int MAG_W     = 32;
    localparam int PHASE_W   = 16;
    localparam int TOTAL_W   = 4;

    typedef struct packed {
        logic [MAG_W-1:0]          bin_magnitude;
        logic signed [PHASE_W-1:0] bin_phase;
        logic                      last_bin;
    } spp_in_t;

    typedef struct packed {
        logic [BIN_W-1:0]          peak_bin;
        logic [MAG_W-1:0]          peak_magnitude;
        logic signed [PHASE_W-1:0] peak_phase;
        logic                      peak_present;
        logic [TOTAL_W-1:0]        peak_total;
        logic                      last_peak;
    } spp_out_t;

    typedef struct packed {
        logic [BIN_W-1:0]          bin;
        logic [MAG_W-1:0]          mag;
        logic signed [PHASE_W-1:0] phase;
    } spp_entry_t;

    typedef struct packed {
        logic       hit;
        spp_entry_t entry;
    } spp_cand_t;

    typedef struct packed {
        logic insert;
        logic shift;
    } spp_cell_ctl_t;

    typedef enum logic [0:0] {
        ST_RUN,
        ST_DRAIN
    } spp_state_t;

endpackage

`default_nettype wire

/* rtl/spp_detect.sv */
// three-bin window, bin counter and local-maximum test
`default_nettype none

module spp_detect (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         accept,
    input  wire spp_pkg::spp_in_t             bin_in,
    input  wire logic [spp_pkg::MAG_W-1:0]    threshold,
    output spp_pkg::spp_cand_t                cand
);

    logic [spp_pkg::MAG_W-1:0]          prior_mag_reg, prior_mag_next;
    logic [spp_pkg::MAG_W-1:0]          older_mag_reg, older_mag_next;
    logic signed [spp_pkg::PHASE_W-1:0] prior_phase_reg, prior_phase_next;
    logic [spp_pkg::BIN_W-1:0]          count_reg, count_next;

    always_comb
    begin
        cand.hit = (count_reg >= spp_pkg::BIN_W'(2))
                   && (prior_mag_reg > threshold)
                   && (prior_mag_reg > older_mag_reg)
                   && (prior_mag_reg > bin_in.bin_magnitude);
        cand.entry.bin   = count_reg - spp_pkg::BIN_W'(1);
        cand.entry.mag   = prior_mag_reg;
        cand.entry.phase = prior_phase_reg;
    end

    always_comb
    begin
        prior_mag_next   = prior_mag_reg;
        older_mag_next   = older_mag_reg;
        prior_phase_next = prior_phase_reg;
        count_next       = count_reg;
        if (accept)
        begin
            if (bin_in.last_bin)
            begin
                prior_mag_next   = '0;
                older_mag_next   = '0;
                prior_phase_next = '0;
                count_next       = '0;
            end
            else
            begin
                older_mag_next   = prior_mag_reg;
                prior_mag_next   = bin_in.bin_magnitude;
                prior_phase_next = bin_in.bin_phase;
                if (count_reg != spp_pkg::BIN_W'(spp_pkg::MAX_BINS - 1))
                begin
                    count_next = count_reg + spp_pkg::BIN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prior_mag_reg   <= '0;
            older_mag_reg   <= '0;
            prior_phase_reg <= '0;
            count_reg       <= '0;
        end
        else
        begin
            prior_mag_reg   <= prior_mag_next;
            older_mag_reg   <= older_mag_next;
            prior_phase_reg <= prior_phase_next;
            count_reg       <= count_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/spp_cell.sv */
// one slot of the sorted peak chain
`default_nettype none

module spp_cell (
    input  wire logic                  clk,
    input  wire spp_pkg::spp_cell_ctl_t ctl,
    input  wire spp_pkg::spp_entry_t   new_entry,
    input  wire spp_pkg::spp_entry_t   left_entry,
    input  wire spp_pkg::spp_entry_t   right_entry,
    input  wire logic                  occupied,
    input  wire logic                  left_keep,
    output spp_pkg::spp_entry_t        entry,
    output logic                       keep
);

    spp_pkg::spp_entry_t entry_reg, entry_next;

    assign entry = entry_reg;
    // equal magnitudes stay ahead of the newcomer
    assign keep  = occupied && (entry_reg.mag >= new_entry.mag);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.insert && !keep)
        begin
            entry_next = left_keep ? new_entry : left_entry;
        end
        else if (ctl.shift)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

/* rtl/spectral_peak_picker.sv */
// top level of the spectral peak picker
`default_nettype none

// Streams one spectrum bin per request and accepts a bin every cycle while a
// frame is running; a found peak is sorted into a chain of MAX_PEAKS cells in
// the same cycle, so the bin stream never waits on an insertion. The bin
// marked last_bin ends the frame: input then stalls while the chain shifts
// its peaks out through the output register, one per cycle when the output
// side takes them. An empty frame yields a single request with peak_present
// low. Peaks come out in descending magnitude, equal magnitudes in frequency
// order; only the first MAX_PEAKS peaks of a frame are kept and the bin
// index saturates.

module spectral_peak_picker (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wr_en,
    input  wire logic [spp_pkg::MAG_W-1:0] cfg_wr_data,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire spp_pkg::spp_in_t          in_data,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output spp_pkg::spp_out_t              out_data
);

    spp_pkg::spp_state_t state_reg, state_next;

    logic [spp_pkg::MAG_W-1:0]  thr_reg;
    logic [spp_pkg::HELD_W-1:0] held_reg, held_next;
    logic [spp_pkg::HELD_W-1:0] total_reg, total_next;
    logic                       empty_reg, empty_next;
    logic                       out_valid_reg, out_valid_next;
    spp_pkg::spp_out_t          out_reg, out_item;

    logic                       in_accept;
    logic                       frame_end;
    logic                       do_insert;
    logic                       out_load;
    logic                       do_shift;
    logic [spp_pkg::HELD_W-1:0] held_ins;

    spp_pkg::spp_cand_t     cand;
    spp_pkg::spp_cell_ctl_t cell_ctl;
    spp_pkg::spp_entry_t    cell_entry [spp_pkg::MAX_PEAKS];
    logic                   cell_keep  [spp_pkg::MAX_PEAKS];

    assign in_accept = in_valid && !in_stall;
    assign frame_end = in_accept && in_data.last_bin;
    assign do_insert = in_accept && cand.hit
                       && (held_reg < spp_pkg::HELD_W'(spp_pkg::MAX_PEAKS));
    assign held_ins  = held_reg + spp_pkg::HELD_W'(do_insert);
    assign do_shift  = out_load && !empty_reg;

    assign cell_ctl.insert = do_insert;
    assign cell_ctl.shift  = do_shift;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    spp_detect u_detect (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .bin_in    (in_data),
        .threshold (thr_reg),
        .cand      (cand)
    );

    for (genvar i = 0; i < spp_pkg::MAX_PEAKS; i++)
    begin : g_cell
        spp_pkg::spp_entry_t left_e;
        spp_pkg::spp_entry_t right_e;
        logic                left_k;

        if (i == 0)
        begin : g_first
            assign left_e = cand.entry;
            assign left_k = 1'b1;
        end
        else
        begin : g_inner
            assign left_e = cell_entry[i-1];
            assign left_k = cell_keep[i-1];
        end

        if (i == spp_pkg::MAX_PEAKS - 1)
        begin : g_last
            assign right_e = '0;
        end
        else
        begin : g_mid
            assign right_e = cell_entry[i+1];
        end

        spp_cell u_cell (
            .clk         (clk),
            .ctl         (cell_ctl),
            .new_entry   (cand.entry),
            .left_entry  (left_e),
            .right_entry (right_e),
            .occupied    (held_reg > spp_pkg::HELD_W'(i)),
            .left_keep   (left_k),
            .entry       (cell_entry[i]),
            .keep        (cell_keep[i])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spp_pkg::ST_RUN:
            begin
                if (frame_end)
                begin
                    state_next = spp_pkg::ST_DRAIN;
                end
            end
            spp_pkg::ST_DRAIN:
            begin
                if (out_load && (empty_reg || (held_reg == spp_pkg::HELD_W'(1))))
                begin
                    state_next = spp_pkg::ST_RUN;
                end
            end
            default:
            begin
                state_next = spp_pkg::ST_RUN;
            end
        endcase
    end

    always_comb
    begin
        in_stall = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            spp_pkg::ST_RUN:
            begin
                in_stall = 1'b0;
            end
            spp_pkg::ST_DRAIN:
            begin
                in_stall = 1'b1;
                out_load = !out_valid_reg || !out_stall;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        out_item = '0;
        if (empty_reg)
        begin
            out_item.last_peak = 1'b1;
        end
        else
        begin
            out_item.peak_bin       = cell_entry[0].bin;
            out_item.peak_magnitude = cell_entry[0].mag;
            out_item.peak_phase     = cell_entry[0].phase;
            out_item.peak_present   = 1'b1;
            out_item.peak_total     = spp_pkg::TOTAL_W'(total_reg);
            out_item.last_peak      = (held_reg == spp_pkg::HELD_W'(1));
        end
    end

    always_comb
    begin
        held_next      = held_reg;
        total_next     = total_reg;
        empty_next     = empty_reg;
        out_valid_next = out_valid_reg;
        if (do_insert)
        begin
            held_next = held_ins;
        end
        else if (do_shift)
        begin
            held_next = held_reg - spp_pkg::HELD_W'(1);
        end
        if (frame_end)
        begin
            total_next = held_ins;
            empty_next = (held_ins == '0);
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spp_pkg::ST_RUN;
            thr_reg       <= '0;
            held_reg      <= '0;
            total_reg     <= '0;
            empty_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            total_reg     <= total_next;
            empty_reg     <= empty_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                thr_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= out_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/spp_checker.sv */
// port-level checks of the spectral peak picker and their binding
`default_nettype none

`include "spectral_peak_picker_defines.svh"

module spp_checker (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wr_en,
    input  wire logic [spp_pkg::MAG_W-1:0] cfg_wr_data,
    input  wire logic                      in_valid,
    input  wire logic                      in_stall,
    input  wire spp_pkg::spp_in_t          in_data,
    input  wire logic                      out_valid,
    input  wire logic                      out_stall,
    input  wire spp_pkg::spp_out_t         out_data
);

    logic out_take;

    assign out_take = out_valid && !out_stall;

    `SPP_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(out_data), "stalled output request changed")

    `SPP_ASSERT_NEXT(a_frame_end_stall, in_valid && !in_stall && in_data.last_bin,
        in_stall, "input not stalled after last bin")

    `SPP_ASSERT_NOW(a_empty_item, out_valid && !out_data.peak_present,
        out_data.last_peak && (out_data.peak_total == '0), "malformed empty frame request")

    `SPP_ASSERT_NEXT(a_burst_total, out_take && !out_data.last_peak,
        out_valid && (out_data.peak_total == $past(out_data.peak_total)),
        "peak burst broken or count changed")

    `SPP_ASSERT_NEXT(a_descending, out_take && !out_data.last_peak,
        out_data.peak_magnitude <= $past(out_data.peak_magnitude),
        "peaks not in descending magnitude")

endmodule

bind spectral_peak_picker spp_checker u_spp_checker (.*);

`default_nettype wire

/* dv/spectral_peak_picker_checker.sv */
// checker for the spectral peak picker: tracks bins, predicts peak reports and compares them
module spectral_peak_picker_checker
    import spp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [MAG_W-1:0] cfg_wr_data,
    input  logic             in_valid,
    input  logic             in_stall,
    input  spp_in_t          in_data,
    input  logic             out_valid,
    input  logic             out_stall,
    input  spp_out_t         out_data,
    output int               mismatches,
    output int               reports_due
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [MAG_W-1:0]          threshold;
    logic [MAG_W-1:0]          prev_mag;
    logic [MAG_W-1:0]          older_mag;
    logic signed [PHASE_W-1:0] prev_phase;
    logic [BIN_W-1:0]          bin_idx;
    int                        n_held;
    spp_entry_t                held [MAX_PEAKS];
    spp_out_t                  peak_reports [$];

    task automatic clear_frame();
        prev_mag   = '0;
        older_mag  = '0;
        prev_phase = '0;
        bin_idx    = '0;
        n_held     = 0;
        for (int i = 0; i < MAX_PEAKS; i++)
        begin
            held[i] = '0;
        end
    endtask

    task automatic keep_peak(input spp_entry_t pk);
        int pos;
        pos = 0;
        if (n_held < MAX_PEAKS)
        begin
            while (pos < n_held && held[pos].mag >= pk.mag)
            begin
                pos++;
            end
            for (int i = n_held; i > pos; i--)
            begin
                held[i] = held[i-1];
            end
            held[pos] = pk;
            n_held++;
        end
    endtask

    task automatic track_bin(input spp_in_t b);
        spp_entry_t pk;
        spp_out_t   rpt;
        if (bin_idx >= 2 && prev_mag > threshold && prev_mag > older_mag &&
            prev_mag > b.bin_magnitude)
        begin
            pk.bin   = bin_idx - 1'b1;
            pk.mag   = prev_mag;
            pk.phase = prev_phase;
            keep_peak(pk);
        end
        older_mag  = prev_mag;
        prev_mag   = b.bin_magnitude;
        prev_phase = b.bin_phase;
        if (bin_idx < MAX_BINS - 1)
        begin
            bin_idx++;
        end
        if (b.last_bin)
        begin
            if (n_held == 0)
            begin
                rpt           = '0;
                rpt.last_peak = 1'b1;
                peak_reports.push_back(rpt);
            end
            else
            begin
                for (int i = 0; i < n_held; i++)
                begin
                    rpt.peak_bin       = held[i].bin;
                    rpt.peak_magnitude = held[i].mag;
                    rpt.peak_phase     = held[i].phase;
                    rpt.peak_present   = 1'b1;
                    rpt.peak_total     = TOTAL_W'(n_held);
                    rpt.last_peak      = (i + 1 == n_held);
                    peak_reports.push_back(rpt);
                end
            end
            clear_frame();
        end
    endtask

    task automatic check_report(input spp_out_t got);
        spp_out_t want;
        if (peak_reports.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected request: bin %0d mag %h phase %0d present %0b total %0d last %0b",
                         got.peak_bin, got.peak_magnitude, got.peak_phase,
                         got.peak_present, got.peak_total, got.last_peak);
        end
        else
        begin
            want = peak_reports.pop_front();
            if (got.peak_bin !== want.peak_bin || got.peak_magnitude !== want.peak_magnitude ||
                got.peak_phase !== want.peak_phase || got.peak_present !== want.peak_present ||
                got.peak_total !== want.peak_total || got.last_peak !== want.last_peak)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch at %0t ns", $realtime);
                    $display("  expected: bin %0d mag %h phase %0d present %0b total %0d last %0b",
                             want.peak_bin, want.peak_magnitude, want.peak_phase,
                             want.peak_present, want.peak_total, want.last_peak);
                    $display("  actual:   bin %0d mag %h phase %0d present %0b total %0d last %0b",
                             got.peak_bin, got.peak_magnitude, got.peak_phase,
                             got.peak_present, got.peak_total, got.last_peak);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_frame();
            threshold = '0;
            peak_reports.delete();
            reports_due = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                check_report(out_data);
            if (cfg_wr_en)
                threshold = cfg_wr_data;
            if (in_valid && !in_stall)
                track_bin(in_data);
            reports_due = peak_reports.size();
        end
    end

endmodule

/* dv/spectral_peak_picker_tb.sv */
// testbench top for the spectral peak picker: clock, reset, bin stream, report sink, verdict
module spectral_peak_picker_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import spp_pkg::*;

    localparam int BIN_ITEMS  = 420;
    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_LEN   = 300;

    logic             clk;
    logic             rst_n;
    logic             cfg_wr_en;
    logic [MAG_W-1:0] cfg_wr_data;
    logic             in_valid;
    logic             in_stall;
    spp_in_t          in_data;
    logic             out_valid;
    logic             out_stall;
    spp_out_t         out_data;

    int               mismatches;
    int               reports_due;
    int               items_sent;
    int               idle_cycles;
    logic             steady;
    logic             hold_go;
    logic [MAG_W-1:0] cur_threshold;

    spectral_peak_picker u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

    spectral_peak_picker_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .mismatches  (mismatches),
        .reports_due (reports_due)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [MAG_W-1:0] pick_threshold();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return MAG_W'($urandom_range(1, 6));
            5:       return MAG_W'($urandom >> 12);
            default: return MAG_W'($urandom);
        endcase
    endfunction

    task automatic send_bin(input logic [MAG_W-1:0] mag, input logic signed [PHASE_W-1:0] phase,
                            input logic last);
        int      gap;
        spp_in_t b;
        gap = steady ? 0 : pick_gap();
        b.bin_magnitude = mag;
        b.bin_phase     = phase;
        b.last_bin      = last;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic send_list(input logic [MAG_W-1:0] mags [$]);
        foreach (mags[i])
        begin
            send_bin(mags[i], PHASE_W'($urandom), i == mags.size() - 1);
        end
    endtask

    task automatic wait_drained(input int settle);
        in_valid <= 1'b0;
        @(negedge clk);
        while (reports_due != 0) @(negedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [MAG_W-1:0] value);
        wait_drained(4);
        cfg_wr_en     <= 1'b1;
        cfg_wr_data   <= value;
        cur_threshold  = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_random_frame();
        int len;
        int mode;
        int r;
        logic [MAG_W-1:0] mag;
        r    = $urandom_range(0, 99);
        mode = $urandom_range(0, 3);
        if (r < 15)
            len = $urandom_range(1, 3);
        else if (r < 90)
            len = $urandom_range(4, 24);
        else
            len = $urandom_range(25, 60);
        for (int i = 0; i < len; i++)
        begin
            case (mode)
                0:       mag = $urandom;
                1:       mag = MAG_W'($urandom_range(0, 7));
                2:       mag = cur_threshold + MAG_W'($urandom_range(0, 4)) - MAG_W'(2);
                default: mag = ($urandom_range(0, 3) == 0) ? ~MAG_W'($urandom_range(0, 3))
                                                             : MAG_W'($urandom_range(0, 3));
            endcase
            send_bin(mag, PHASE_W'($urandom), i == len - 1);
        end
    endtask

    // report sink with random stalls and one long hold-off
    initial
    begin
        int  r;
        bit  hold_done;
        hold_done = 1'b0;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            r = $urandom_range(0, 99);
            if (hold_go && !hold_done)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_LEN) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (r < 50)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else if (r < 85)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            else if (r < 95)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(20, 60)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(10, 40)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int frames;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        in_valid      = 1'b0;
        in_data       = '0;
        steady        = 1'b0;
        hold_go       = 1'b0;
        items_sent    = 0;
        idle_cycles   = 0;
        cur_threshold = '0;
        frames        = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single bin, two bins, then a lone peak at full scale
        send_list('{MAG_W'(5)});
        send_list('{'1, '1});
        send_bin('0, 16'sh8000, 1'b0);
        send_bin('1, 16'sh8000, 1'b0);
        send_bin('0, 16'sh7fff, 1'b1);
        // equal peaks in frequency order, high first bin, plateau, high last bin
        send_list('{9, 0, 5, 0, 5, 1, 1, 8});
        write_threshold(4);
        send_list('{0, 4, 0, 5, 0});
        write_threshold('1);
        send_list('{0, '1, 0});

        hold_go <= 1'b1;
        while (items_sent < BIN_ITEMS)
        begin
            if (frames % 5 == 0)
            begin
                write_threshold(pick_threshold());
                steady = ($urandom_range(0, 3) == 0);
            end
            send_random_frame();
            frames++;
        end

        wait_drained(20);
        @(negedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
